// ===== rtl/core/ppd_pkg.sv =====
package ppd_pkg;

  // queue and nesting stack sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_DEPTH  = 16;

  // address and count widths
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NA_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NL_W = $clog2(NEST_DEPTH + 1);

  // field widths
  localparam int OP_W    = 2;
  localparam int PRIO_W  = 8;
  localparam int FN_W    = 32;
  localparam int ARG_W   = 64;
  localparam int STAT_W  = 4;
  localparam int CNT_O_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_QUEUED          = 4'd0;
  localparam logic [STAT_W-1:0] ST_NO_FUNCTION     = 4'd1;
  localparam logic [STAT_W-1:0] ST_FULL            = 4'd2;
  localparam logic [STAT_W-1:0] ST_DISPATCHED      = 4'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY           = 4'd4;
  localparam logic [STAT_W-1:0] ST_HELD            = 4'd5;
  localparam logic [STAT_W-1:0] ST_RESTORED        = 4'd6;
  localparam logic [STAT_W-1:0] ST_NOTHING_RUNNING = 4'd7;
  localparam logic [STAT_W-1:0] ST_NEST_FULL       = 4'd8;

  // one queue slot
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [FN_W-1:0]   fn;
    logic [ARG_W-1:0]  arg;
  } slot_t;

  // one saved context
  typedef struct packed {
    logic              running;
    logic [PRIO_W-1:0] prio;
  } ctx_t;

  // requests from the sequencer to the queue
  typedef struct packed {
    logic push;
    logic peek;
    logic pop;
  } q_req_t;

  // queue answer
  typedef struct packed {
    logic done;
  } q_rsp_t;

endpackage

// ===== rtl/core/ppd_in_if.sv =====
interface ppd_in_if
  import ppd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PRIO_W-1:0] task_priority;
  logic [FN_W-1:0]   task_function;
  logic [ARG_W-1:0]  task_argument;

  modport source (
    output valid, operation, task_priority, task_function, task_argument,
    input  ready
  );

  modport sink (
    input  valid, operation, task_priority, task_function, task_argument,
    output ready
  );
endinterface

// ===== rtl/core/ppd_out_if.sv =====
interface ppd_out_if
  import ppd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [FN_W-1:0]    out_function;
  logic [ARG_W-1:0]   out_argument;
  logic [PRIO_W-1:0]  out_priority;
  logic [CNT_O_W-1:0] pending_count;
  logic [CNT_O_W-1:0] nesting_level;

  modport source (
    output valid, status, out_function, out_argument, out_priority,
    pending_count, nesting_level,
    input  ready
  );

  modport sink (
    input  valid, status, out_function, out_argument, out_priority,
    pending_count, nesting_level,
    output ready
  );
endinterface

// ===== rtl/core/ppd_queue.sv =====
module ppd_queue
  import ppd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_req_t            req,
  input  slot_t             new_slot,
  output q_rsp_t            rsp,
  output slot_t             head_slot,
  output logic [QC_W-1:0]   count
);

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_WALK = 2'd1;
  localparam logic [1:0] Q_INS  = 2'd2;
  localparam logic [1:0] Q_PEEK = 2'd3;

  slot_t             mem [QUEUE_DEPTH];
  slot_t             rd_r;
  logic [1:0]        state_r, state_nxt;
  logic [QA_W-1:0]   head_r, head_nxt;
  logic [QC_W-1:0]   count_r, count_nxt;
  logic [QC_W-1:0]   k_r, k_nxt;
  logic              rd_en, wr_en, done, inc;
  logic [QA_W-1:0]   rd_addr, wr_addr;
  slot_t             wr_data;

  // logical position to ring address
  function automatic logic [QA_W-1:0] phys(input logic [QA_W-1:0] base,
                                           input logic [QC_W-1:0] ofs);
    logic [QC_W:0] sum;
    sum = (QC_W+1)'(base) + (QC_W+1)'(ofs);
    if (sum >= (QC_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (QC_W+1)'(QUEUE_DEPTH);
    end
    return sum[QA_W-1:0];
  endfunction

  // insertion walk from the tail toward the head, and head read for a peek
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    wr_data   = new_slot;
    done      = 1'b0;
    inc       = 1'b0;
    unique case (state_r)
      Q_IDLE: begin
        if (req.push) begin
          k_nxt = count_r;
          if (count_r == '0) begin
            state_nxt = Q_INS;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = phys(head_r, count_r - QC_W'(1));
            state_nxt = Q_WALK;
          end
        end else if (req.peek) begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = Q_PEEK;
        end
      end
      Q_WALK: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, k_r);
        if (rd_r.prio > new_slot.prio) begin
          wr_data = rd_r;
          k_nxt   = k_r - QC_W'(1);
          if (k_r == QC_W'(1)) begin
            state_nxt = Q_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, k_r - QC_W'(2));
          end
        end else begin
          done      = 1'b1;
          inc       = 1'b1;
          state_nxt = Q_IDLE;
        end
      end
      Q_INS: begin
        wr_en     = 1'b1;
        wr_addr   = phys(head_r, k_r);
        done      = 1'b1;
        inc       = 1'b1;
        state_nxt = Q_IDLE;
      end
      Q_PEEK: begin
        done      = 1'b1;
        state_nxt = Q_IDLE;
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  // head and count bookkeeping
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (req.pop) begin
      head_nxt  = phys(head_r, QC_W'(1));
      count_nxt = count_r - QC_W'(1);
    end else if (inc) begin
      count_nxt = count_r + QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rsp.done  = done;
  assign head_slot = rd_r;
  assign count     = count_r;

endmodule

// ===== rtl/core/preemptive_priority_task_dispatcher.sv =====
// one item at a time: an accepted item is decoded, then a push walks the queue,
// a dispatch peeks the queue head, a complete reads the nesting stack, and refused
// or ignored operations go straight to the result stage; the push walk visits the
// slot memory from tail to head, one entry per cycle, shifting each queued task
// strictly less urgent than the new one; the next item can be taken in the cycle
// after the result goes valid, and a stalled result waits in the result stage
// and holds off the next item; synchronous active-low reset empties the queue and
// the nesting stack and clears the running context; memories are not cleared
module preemptive_priority_task_dispatcher
  import ppd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ppd_in_if.sink     in_chan,
  ppd_out_if.source  out_chan
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_PEEK = 3'd3;
  localparam logic [2:0] S_STK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r;
  slot_t              new_r;
  logic               run_flag_r;
  logic [PRIO_W-1:0]  run_prio_r;
  logic [NL_W-1:0]    level_r;
  logic [NL_W-1:0]    level_dec;
  ctx_t               stk_mem [NEST_DEPTH];
  ctx_t               stk_rd_r;
  logic               stk_wr, stk_rd;
  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [FN_W-1:0]    res_fn_r, res_fn_nxt;
  logic [ARG_W-1:0]   res_arg_r, res_arg_nxt;
  logic               res_load;
  logic               dispatch_go, restore_go, out_load;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [FN_W-1:0]    out_fn_r;
  logic [ARG_W-1:0]   out_arg_r;
  logic [PRIO_W-1:0]  out_prio_r;
  logic [CNT_O_W-1:0] out_pend_r;
  logic [CNT_O_W-1:0] out_nest_r;
  q_req_t             q_req;
  q_rsp_t             q_rsp;
  slot_t              q_head;
  logic [QC_W-1:0]    q_count;
  logic               accept;

  ppd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (q_req),
    .new_slot  (new_r),
    .rsp       (q_rsp),
    .head_slot (q_head),
    .count     (q_count)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign level_dec     = level_r - NL_W'(1);
  assign out_load      = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  // operation sequencer
  always_comb begin
    state_nxt      = state_r;
    q_req          = '0;
    stk_wr         = 1'b0;
    stk_rd         = 1'b0;
    res_load       = 1'b0;
    res_status_nxt = ST_NOTHING_RUNNING;
    res_fn_nxt     = '0;
    res_arg_nxt    = '0;
    dispatch_go    = 1'b0;
    restore_go     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (op_r)
          OP_PUSH: begin
            if (new_r.fn == '0) begin
              res_load       = 1'b1;
              res_status_nxt = ST_NO_FUNCTION;
              state_nxt      = S_OUT;
            end else if (q_count >= QC_W'(QUEUE_DEPTH)) begin
              res_load       = 1'b1;
              res_status_nxt = ST_FULL;
              state_nxt      = S_OUT;
            end else begin
              q_req.push = 1'b1;
              state_nxt  = S_PUSH;
            end
          end
          OP_DISPATCH: begin
            if (q_count == '0) begin
              res_load       = 1'b1;
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              q_req.peek = 1'b1;
              state_nxt  = S_PEEK;
            end
          end
          OP_COMPLETE: begin
            if (level_r == '0) begin
              res_load       = 1'b1;
              res_status_nxt = ST_NOTHING_RUNNING;
              state_nxt      = S_OUT;
            end else begin
              stk_rd    = 1'b1;
              state_nxt = S_STK;
            end
          end
          default: begin
            res_load       = 1'b1;
            res_status_nxt = ST_NOTHING_RUNNING;
            state_nxt      = S_OUT;
          end
        endcase
      end
      S_PUSH: begin
        if (q_rsp.done) begin
          res_load       = 1'b1;
          res_status_nxt = ST_QUEUED;
          state_nxt      = S_OUT;
        end
      end
      S_PEEK: begin
        if (q_rsp.done) begin
          res_load  = 1'b1;
          state_nxt = S_OUT;
          priority if (run_flag_r && (q_head.prio >= run_prio_r)) begin
            res_status_nxt = ST_HELD;
          end else if (level_r >= NL_W'(NEST_DEPTH)) begin
            res_status_nxt = ST_NEST_FULL;
          end else begin
            res_status_nxt = ST_DISPATCHED;
            res_fn_nxt     = q_head.fn;
            res_arg_nxt    = q_head.arg;
            q_req.pop      = 1'b1;
            stk_wr         = 1'b1;
            dispatch_go    = 1'b1;
          end
        end
      end
      S_STK: begin
        res_load       = 1'b1;
        res_status_nxt = ST_RESTORED;
        restore_go     = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and running context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_flag_r  <= 1'b0;
      run_prio_r  <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (dispatch_go) begin
        run_flag_r <= 1'b1;
        run_prio_r <= q_head.prio;
        level_r    <= level_r + NL_W'(1);
      end else if (restore_go) begin
        run_flag_r <= stk_rd_r.running;
        run_prio_r <= stk_rd_r.prio;
        level_r    <= level_dec;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // latched item and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_chan.operation;
      new_r.prio <= in_chan.task_priority;
      new_r.fn   <= in_chan.task_function;
      new_r.arg  <= in_chan.task_argument;
    end
    if (res_load) begin
      res_status_r <= res_status_nxt;
      res_fn_r     <= res_fn_nxt;
      res_arg_r    <= res_arg_nxt;
    end
  end

  // nesting stack memory
  always_ff @(posedge clk) begin
    if (stk_wr) begin
      stk_mem[level_r[NA_W-1:0]] <= '{running: run_flag_r, prio: run_prio_r};
    end
    if (stk_rd) begin
      stk_rd_r <= stk_mem[level_dec[NA_W-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_fn_r     <= res_fn_r;
      out_arg_r    <= res_arg_r;
      out_prio_r   <= run_prio_r;
      out_pend_r   <= CNT_O_W'(q_count);
      out_nest_r   <= CNT_O_W'(level_r);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.out_function  = out_fn_r;
  assign out_chan.out_argument  = out_arg_r;
  assign out_chan.out_priority  = out_prio_r;
  assign out_chan.pending_count = out_pend_r;
  assign out_chan.nesting_level = out_nest_r;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QC_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_nest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= NL_W'(NEST_DEPTH))
    else $error("nesting level beyond depth");

  a_dispatch_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    dispatch_go |=> run_flag_r && (level_r == $past(level_r) + NL_W'(1)))
    else $error("dispatch did not push a context");

  a_dispatched_fn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_DISPATCHED)) |-> (out_fn_r != '0))
    else $error("dispatched item without a handler");

endmodule

// ===== tb/preemptive_priority_task_dispatcher_tb.sv =====
`timescale 1ns / 100ps

module preemptive_priority_task_dispatcher_tb;
  import ppd_pkg::*;

  // operation code the block ignores
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT    = 10;

  // one expected result item
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FN_W-1:0]    fn;
    logic [ARG_W-1:0]   arg;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_O_W-1:0] pending;
    logic [CNT_O_W-1:0] nesting;
  } dispatch_report_t;

  logic clk;
  logic rst_n;

  ppd_in_if  in_chan ();
  ppd_out_if out_chan ();

  preemptive_priority_task_dispatcher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted dispatcher state
  slot_t            waiting_tasks[$];
  ctx_t             saved_contexts[$];
  logic             running_now;
  logic [PRIO_W-1:0] running_prio;

  dispatch_report_t expected_reports[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_requests;
  int unsigned hold_off_served;
  int unsigned hold_off_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // works out the result of one accepted item and advances the state
  function automatic dispatch_report_t predict_dispatcher(
    input logic [OP_W-1:0]   op,
    input logic [PRIO_W-1:0] prio,
    input logic [FN_W-1:0]   fn,
    input logic [ARG_W-1:0]  arg
  );
    dispatch_report_t rep;
    slot_t            entry;
    ctx_t             ctx;
    int               pos;
    rep = '0;
    case (op)
      OP_PUSH: begin
        if (fn == '0) begin
          rep.status = ST_NO_FUNCTION;
        end else if (waiting_tasks.size() >= QUEUE_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          // behind every task of equal or more urgent priority
          pos = 0;
          while (pos < waiting_tasks.size() && waiting_tasks[pos].prio <= prio) pos++;
          entry.prio = prio;
          entry.fn   = fn;
          entry.arg  = arg;
          waiting_tasks.insert(pos, entry);
          rep.status = ST_QUEUED;
        end
      end
      OP_DISPATCH: begin
        if (waiting_tasks.size() == 0) begin
          rep.status = ST_EMPTY;
        end else if (running_now && waiting_tasks[0].prio >= running_prio) begin
          rep.status = ST_HELD;
        end else if (saved_contexts.size() >= NEST_DEPTH) begin
          rep.status = ST_NEST_FULL;
        end else begin
          entry = waiting_tasks.pop_front();
          ctx.running = running_now;
          ctx.prio    = running_prio;
          saved_contexts.push_back(ctx);
          running_now  = 1'b1;
          running_prio = entry.prio;
          rep.fn     = entry.fn;
          rep.arg    = entry.arg;
          rep.status = ST_DISPATCHED;
        end
      end
      OP_COMPLETE: begin
        if (saved_contexts.size() == 0) begin
          rep.status = ST_NOTHING_RUNNING;
        end else begin
          ctx = saved_contexts.pop_back();
          running_now  = ctx.running;
          running_prio = ctx.prio;
          rep.status   = ST_RESTORED;
        end
      end
      default: begin
        rep.status = ST_NOTHING_RUNNING;
      end
    endcase
    rep.prio    = running_prio;
    rep.pending = CNT_O_W'(waiting_tasks.size());
    rep.nesting = CNT_O_W'(saved_contexts.size());
    return rep;
  endfunction

  // offers one item, waits for it to be taken, records its expected result
  task automatic send_item(
    input logic [OP_W-1:0]   op,
    input logic [PRIO_W-1:0] prio,
    input logic [FN_W-1:0]   fn,
    input logic [ARG_W-1:0]  arg
  );
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= op;
    in_chan.task_priority <= prio;
    in_chan.task_function <= fn;
    in_chan.task_argument <= arg;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    expected_reports.push_back(predict_dispatcher(op, prio, fn, arg));
  endtask

  // non-push item with random payload bits
  task automatic send_noise(input logic [OP_W-1:0] op);
    send_item(op, PRIO_W'($urandom), $urandom, {$urandom, $urandom});
  endtask

  // empties the nesting stack and the pending queue
  task automatic drain_dispatcher();
    while (saved_contexts.size() != 0) send_noise(OP_COMPLETE);
    while (waiting_tasks.size() != 0) begin
      send_noise(OP_DISPATCH);
      send_noise(OP_COMPLETE);
    end
  endtask

  task automatic test_idle_operations();
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    send_item(OP_COMPLETE, 8'hff, 32'hffff_ffff, {ARG_W{1'b1}});
    send_item(OP_IGNORED, 8'hff, 32'hffff_ffff, {ARG_W{1'b1}});
    // handler zero is refused
    send_item(OP_PUSH, 8'hff, 32'h0, {ARG_W{1'b1}});
  endtask

  task automatic test_push_ordering();
    send_item(OP_PUSH, 8'hff, 32'h1, 64'h0);
    send_item(OP_PUSH, 8'h00, 32'hffff_ffff, {ARG_W{1'b1}});
    // tie goes behind the earlier task
    send_item(OP_PUSH, 8'h00, 32'h2, 64'h1);
    send_item(OP_PUSH, 8'h80, 32'h3, 64'h5555_aaaa_5555_aaaa);
  endtask

  task automatic test_dispatch_preemption();
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    // equal priority does not preempt
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    send_item(OP_COMPLETE, 8'h00, 32'h0, 64'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    send_item(OP_COMPLETE, 8'h00, 32'h0, 64'h0);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    // more urgent task nests over the running one
    send_item(OP_PUSH, 8'h7f, 32'h4, 64'haaaa_5555_aaaa_5555);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    send_item(OP_PUSH, 8'h7f, 32'h5, 64'h0123_4567_89ab_cdef);
    send_item(OP_DISPATCH, 8'h00, 32'h0, 64'h0);
    // restore nested, then a context that was not running
    send_item(OP_COMPLETE, 8'h00, 32'h0, 64'h0);
    send_item(OP_COMPLETE, 8'h00, 32'h0, 64'h0);
  endtask

  task automatic test_nesting_full();
    logic [PRIO_W-1:0] prio;
    drain_dispatcher();
    prio = PRIO_W'($urandom_range(255, 200));
    // each task more urgent than the last, until the stack is full
    repeat (NEST_DEPTH + 1) begin
      send_item(OP_PUSH, prio, $urandom, {$urandom, $urandom});
      send_noise(OP_DISPATCH);
      prio = prio - PRIO_W'($urandom_range(10, 1));
    end
    // unwind past the bottom of the stack
    repeat (NEST_DEPTH + 1) send_noise(OP_COMPLETE);
  endtask

  task automatic test_queue_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_off_requests++;
    repeat (QUEUE_DEPTH + 8) begin
      send_item(OP_PUSH, PRIO_W'($urandom), $urandom, {$urandom, $urandom});
    end
  endtask

  task automatic test_random_traffic(input int unsigned item_total);
    int unsigned       sent;
    int unsigned       burst;
    int unsigned       pick;
    logic [PRIO_W-1:0] prio;
    logic [FN_W-1:0]   fn;
    sent = 0;
    while (sent < item_total) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        // push bursts, some on a narrow band of priorities for ties
        burst = $urandom_range(18, 1);
        repeat (burst) begin
          if ($urandom_range(1, 0) == 0) prio = PRIO_W'($urandom);
          else prio = PRIO_W'($urandom_range(103, 100));
          fn = ($urandom_range(24, 0) == 0) ? '0 : $urandom;
          send_item(OP_PUSH, prio, fn, {$urandom, $urandom});
        end
        sent += burst;
      end else if (pick < 70) begin
        burst = $urandom_range(6, 1);
        repeat (burst) send_noise(OP_DISPATCH);
        sent += burst;
      end else if (pick < 96) begin
        burst = $urandom_range(6, 1);
        repeat (burst) send_noise(OP_COMPLETE);
        sent += burst;
      end else begin
        send_noise(OP_IGNORED);
      end
    end
  endtask

  // result receiver with random stalls and long hold-offs
  initial begin : receiver
    out_chan.ready = 1'b0;
    hold_off_served = 0;
    hold_off_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_off_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_off_left--;
      end else if (hold_off_served != hold_off_requests) begin
        hold_off_served++;
        hold_off_left = HOLD_OFF_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    dispatch_report_t want;
    dispatch_report_t got;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.status  = out_chan.status;
      got.fn      = out_chan.out_function;
      got.arg     = out_chan.out_argument;
      got.prio    = out_chan.out_priority;
      got.pending = out_chan.pending_count;
      got.nesting = out_chan.nesting_level;
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result item: st=%0d fn=%h arg=%h prio=%0d pend=%0d nest=%0d",
                   got.status, got.fn, got.arg, got.prio, got.pending, got.nesting);
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status || got.fn !== want.fn || got.arg !== want.arg ||
            got.prio !== want.prio || got.pending !== want.pending ||
            got.nesting !== want.nesting) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("mismatch expected: st=%0d fn=%h arg=%h prio=%0d pend=%0d nest=%0d",
                     want.status, want.fn, want.arg, want.prio, want.pending, want.nesting);
            $display("         actual:   st=%0d fn=%h arg=%h prio=%0d pend=%0d nest=%0d",
                     got.status, got.fn, got.arg, got.prio, got.pending, got.nesting);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.operation     = OP_PUSH;
    in_chan.task_priority = '0;
    in_chan.task_function = '0;
    in_chan.task_argument = '0;
    running_now           = 1'b0;
    running_prio          = '0;
    error_count           = 0;
    cycle_count           = 0;
    sender_idle_pct       = 0;
    recv_stall_pct        = 0;
    hold_off_requests     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_operations();
    test_push_ordering();
    test_dispatch_preemption();
    test_nesting_full();
    test_queue_backpressure();

    // random traffic under each idling mix
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    test_random_traffic(150);
    sender_idle_pct = 61;
    recv_stall_pct  = 0;
    test_random_traffic(150);
    sender_idle_pct = 0;
    recv_stall_pct  = 61;
    test_random_traffic(150);
    sender_idle_pct = 16;
    recv_stall_pct  = 16;
    test_random_traffic(150);

    in_chan.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ppd_pkg.sv
rtl/core/ppd_in_if.sv
rtl/core/ppd_out_if.sv
rtl/core/ppd_queue.sv
rtl/core/preemptive_priority_task_dispatcher.sv
tb/preemptive_priority_task_dispatcher_tb.sv
